/* rtl/sfcrc_pkg.sv */
// ----------------------------------------------------------------------------
// sfcrc_pkg: shared types, constants and helpers
// CRC-8 update and fixed-point scaling for the sensor reply checker.
// ----------------------------------------------------------------------------
package sfcrc_pkg;

   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned WORD_W   = 16;
   localparam int unsigned VALUE_W  = 15;
   localparam int unsigned PROD_W   = 31;
   localparam int unsigned POS_W    = 3;

   localparam logic [BYTE_W-1:0] CRC_POLY = 8'h31;
   localparam logic [BYTE_W-1:0] CRC_INIT = 8'hFF;

   // Full-scale spans and offsets, in hundredths
   localparam logic [VALUE_W-1:0] TEMP_SPAN   = 15'd17500;
   localparam logic [VALUE_W-1:0] TEMP_OFFSET = 15'd4500;
   localparam logic [VALUE_W-1:0] HUM_SPAN    = 15'd12500;
   localparam logic [VALUE_W-1:0] HUM_OFFSET  = 15'd600;

   // Byte positions inside the six-byte reply frame
   localparam logic [POS_W-1:0] POS_TEMP_HI  = 3'd0;
   localparam logic [POS_W-1:0] POS_TEMP_LO  = 3'd1;
   localparam logic [POS_W-1:0] POS_TEMP_CRC = 3'd2;
   localparam logic [POS_W-1:0] POS_HUM_HI   = 3'd3;
   localparam logic [POS_W-1:0] POS_HUM_LO   = 3'd4;
   localparam logic [POS_W-1:0] POS_HUM_CRC  = 3'd5;

   // Result word, first field in the highest bits
   typedef struct packed {
      logic               hum_crc_ok;
      logic               temp_crc_ok;
      logic [VALUE_W-1:0] hum_centi_pct;
      logic [VALUE_W-1:0] temp_centi_c;
   } rsp_data_type;

   // CRC-8, MSB first, one byte
   function automatic logic [BYTE_W-1:0] crc8_update(input logic [BYTE_W-1:0] crc,
                                                     input logic [BYTE_W-1:0] data);
      logic [BYTE_W-1:0] c;
      c = crc ^ data;
      for (int k = 0; k < BYTE_W; k++) begin
         if (c[BYTE_W-1]) begin
            c = {c[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[BYTE_W-2:0], 1'b0};
         end
      end
      return c;
   endfunction

   // floor(prod / 65535) - offset, 15-bit two's complement.
   // prod = q0*65536 + lo = q0*65535 + (lo + q0); the remainder term stays
   // below twice 65535, so one compare fixes the quotient.
   function automatic logic [VALUE_W-1:0] scale_centi(input logic [PROD_W-1:0]  prod,
                                                      input logic [VALUE_W-1:0] offset);
      logic [VALUE_W-1:0] q0;
      logic [WORD_W:0]    rem;
      logic [VALUE_W-1:0] q;
      q0  = prod[PROD_W-1:WORD_W];
      rem = {1'b0, prod[WORD_W-1:0]} + {2'b00, q0};
      q   = q0 + ((rem >= 17'd65535) ? 15'd1 : 15'd0);
      return q - offset;
   endfunction

endpackage

/* rtl/sensor_frame_crc_check_convert.sv */
// ----------------------------------------------------------------------------
// sensor_frame_crc_check_convert: sensor reply CRC check and unit conversion
// Collects six-byte humidity/temperature replies, checks both CRC-8 fields
// and returns temperature and humidity in hundredths.
// ----------------------------------------------------------------------------
// Usage:
//  - req_ channel: one reply byte per transfer, in frame order: temperature
//    high, temperature low, temperature CRC, humidity high, humidity low,
//    humidity CRC. There is no framing signal; the sixth byte closes a frame.
//  - rsp_ channel: one transfer per frame, carrying both converted values
//    and both CRC-match flags. A bad CRC only clears its flag; values are
//    still converted.
//  - Throughput: one byte per cycle, sustained, with rsp_tready high.
//  - Output: after its transfer the sixth byte is held in the input register,
//    then processed out of it into the result register, which raises
//    rsp_tvalid.
//  - Each word is multiplied by its span when its low byte is processed;
//    the division by 65535 and the offset are applied from that registered
//    product when the frame's last byte is processed.
//  - Stall: a finished result waits in the result register. Bytes keep
//    being taken until the next frame's last byte would overwrite it; then
//    req_tready drops until rsp_tready frees the register.
//  - Reset (synchronous, active high): empties both registers and restarts
//    frame alignment at the temperature high byte.
// ----------------------------------------------------------------------------
module sensor_frame_crc_check_convert (
   input  logic        clock,
   input  logic        reset,
   // Reply bytes
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   // Results
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // [14:0] temp_centi_c, [29:15] hum_centi_pct,
                                    // [30] temp_crc_ok, [31] hum_crc_ok
);

   // Input register
   logic                             in_valid_ff, in_valid_in;
   logic [sfcrc_pkg::BYTE_W-1:0]     in_byte_ff;

   // Frame state
   logic [sfcrc_pkg::POS_W-1:0]      pos_ff, pos_in;
   logic [sfcrc_pkg::BYTE_W-1:0]     crc_ff, crc_in;
   logic [sfcrc_pkg::BYTE_W-1:0]     temp_hi_ff;
   logic [sfcrc_pkg::BYTE_W-1:0]     hum_hi_ff;
   logic [sfcrc_pkg::PROD_W-1:0]     temp_prod_ff;
   logic [sfcrc_pkg::PROD_W-1:0]     hum_prod_ff;
   logic                             temp_ok_ff;

   // Result register
   logic                             rsp_valid_ff, rsp_valid_in;
   sfcrc_pkg::rsp_data_type          rsp_data_ff;

   logic [sfcrc_pkg::POS_W-1:0]      pos_eff;
   logic [sfcrc_pkg::BYTE_W-1:0]     crc_base;
   logic [sfcrc_pkg::BYTE_W-1:0]     crc_next;
   logic                             is_last;
   logic                             advance;
   logic                             process;

   // Positions 6 and 7 never arise; if seen, restart the frame.
   assign pos_eff  = (pos_ff > sfcrc_pkg::POS_HUM_CRC) ? sfcrc_pkg::POS_TEMP_HI : pos_ff;
   assign crc_base = (pos_ff > sfcrc_pkg::POS_HUM_CRC) ? sfcrc_pkg::CRC_INIT : crc_ff;
   assign crc_next = sfcrc_pkg::crc8_update(crc_base, in_byte_ff);
   assign is_last  = (pos_eff == sfcrc_pkg::POS_HUM_CRC);

   // Held byte moves on unless it would overwrite an untaken result
   assign advance  = !in_valid_ff || !is_last || !rsp_valid_ff || rsp_tready;
   assign process  = in_valid_ff && advance;

   assign req_tready = advance;

   always_comb begin
      in_valid_in  = req_tvalid ? 1'b1 : (in_valid_ff && !advance);
      rsp_valid_in = (process && is_last) ? 1'b1 : (rsp_valid_ff && !rsp_tready);
      pos_in       = pos_ff;
      crc_in       = crc_ff;
      if (process) begin
         pos_in = is_last ? sfcrc_pkg::POS_TEMP_HI : pos_eff + 3'd1;
         unique case (pos_eff)
            sfcrc_pkg::POS_TEMP_HI,
            sfcrc_pkg::POS_TEMP_LO,
            sfcrc_pkg::POS_HUM_HI,
            sfcrc_pkg::POS_HUM_LO: begin
               crc_in = crc_next;
            end
            default: begin
               crc_in = sfcrc_pkg::CRC_INIT;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pos_ff       <= sfcrc_pkg::POS_TEMP_HI;
         crc_ff       <= sfcrc_pkg::CRC_INIT;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         pos_ff       <= pos_in;
         crc_ff       <= crc_in;
      end
   end

   // Payload: no reset
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
      end
      if (process) begin
         unique case (pos_eff)
            sfcrc_pkg::POS_TEMP_HI: begin
               temp_hi_ff <= in_byte_ff;
            end
            sfcrc_pkg::POS_TEMP_LO: begin
               temp_prod_ff <= sfcrc_pkg::PROD_W'(sfcrc_pkg::TEMP_SPAN)
                             * sfcrc_pkg::PROD_W'({temp_hi_ff, in_byte_ff});
            end
            sfcrc_pkg::POS_TEMP_CRC: begin
               temp_ok_ff <= (in_byte_ff == crc_base);
            end
            sfcrc_pkg::POS_HUM_HI: begin
               hum_hi_ff <= in_byte_ff;
            end
            sfcrc_pkg::POS_HUM_LO: begin
               hum_prod_ff <= sfcrc_pkg::PROD_W'(sfcrc_pkg::HUM_SPAN)
                            * sfcrc_pkg::PROD_W'({hum_hi_ff, in_byte_ff});
            end
            default: begin
               // humidity CRC byte closes the frame
               rsp_data_ff.temp_centi_c  <= sfcrc_pkg::scale_centi(temp_prod_ff,
                                                                  sfcrc_pkg::TEMP_OFFSET);
               rsp_data_ff.hum_centi_pct <= sfcrc_pkg::scale_centi(hum_prod_ff,
                                                                  sfcrc_pkg::HUM_OFFSET);
               rsp_data_ff.temp_crc_ok   <= temp_ok_ff;
               rsp_data_ff.hum_crc_ok    <= (in_byte_ff == crc_base);
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
